FILE: rtl/ray_sphere_intersect_macros.svh
// Assertion macros for the ray / sphere intersection unit.
// Included by ray_sphere_intersect.sv; no other dependencies.
`ifndef RAY_SPHERE_INTERSECT_MACROS_SVH
`define RAY_SPHERE_INTERSECT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RSI_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("ray_sphere_intersect: assertion failed");
`define RSI_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("ray_sphere_intersect: assertion failed");
`else
`define RSI_ASSERT_IMPL(lbl, clk, rstn, pre, post)
`define RSI_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

FILE: rtl/rsi_pkg.sv
// Shared constants for the ray / sphere intersection unit.
// No dependencies.
`timescale 1ns / 1ps
package rsi_pkg;
  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIST_BITS     = 31;
  localparam int MAT_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MATERIAL = 3'd4;
endpackage

FILE: rtl/ray_sphere_intersect.sv
// Ray / sphere intersection unit, fully pipelined, one ray per clock.
// Depends on rsi_pkg and ray_sphere_intersect_macros.svh.
//
//  channel  | handshake              | words
//  ray in   | start_i, busy_o (0)    | origin_*_i, dir_*_i
//  result   | valid_o strobe         | hit_flag_o .. material_o
//  config   | cfg_we_i, cfg_idx_i    | cfg_data_i
//
// One ray accepted per clock; busy_o is always low.
// Depth: front end, sqrt stages, root select and point stages, divide stages
//   and the output register (54 sqrt + 49 divide stages at 32/16).
// The bit-serial square root (one root bit per stage) and the restoring
//   divider for the normals (one quotient bit per stage) set the depth.
// Reset clears the valid chain and loads the config reset values.
// No stalls: results are presented for one cycle and never held.
`timescale 1ns / 1ps
`include "ray_sphere_intersect_macros.svh"
module ray_sphere_intersect #(
  parameter int WORD_BITS = rsi_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [WORD_BITS-1:0]          origin_x_i,
  input  logic signed [WORD_BITS-1:0]          origin_y_i,
  input  logic signed [WORD_BITS-1:0]          origin_z_i,
  input  logic signed [FRAC_BITS+1:0]          dir_x_i,
  input  logic signed [FRAC_BITS+1:0]          dir_y_i,
  input  logic signed [FRAC_BITS+1:0]          dir_z_i,
  input  logic                                 cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [WORD_BITS-1:0]                 cfg_data_i,
  output logic                                 valid_o,
  output logic                                 hit_flag_o,
  output logic                                 front_face_o,
  output logic [rsi_pkg::DIST_BITS-1:0]        distance_o,
  output logic signed [WORD_BITS-1:0]          point_x_o,
  output logic signed [WORD_BITS-1:0]          point_y_o,
  output logic signed [WORD_BITS-1:0]          point_z_o,
  output logic signed [WORD_BITS-1:0]          normal_x_o,
  output logic signed [WORD_BITS-1:0]          normal_y_o,
  output logic signed [WORD_BITS-1:0]          normal_z_o,
  output logic [rsi_pkg::MAT_BITS-1:0]         material_o
);
  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int W1   = W + 1;
  localparam int DW   = F + 2;
  localparam int RW   = W - 1;
  localparam int OCW  = W + 1;
  localparam int PDW  = DW + OCW;
  localparam int B2W  = PDW + 2;
  localparam int SQOW = 2 * OCW;
  localparam int RRW  = 2 * RW;
  localparam int CCW  = 2 * OCW + 3;
  localparam int LO   = (B2W + 1) / 2;
  localparam int HI   = B2W - LO;
  localparam int BBW  = 2 * B2W;
  localparam int DSA  = BBW + 1;
  localparam int DSB  = CCW + 2 * F;
  localparam int DSW  = ((DSA > DSB) ? DSA : DSB) + 1;
  localparam int SQW  = (DSW + 1) / 2;
  localparam int RDW  = 2 * SQW;
  localparam int TW   = ((B2W > SQW) ? B2W : SQW) + 2;
  localparam int TSW  = TW - F;
  localparam int DTW  = DW + TSW;
  localparam int DSHW = DTW - F;
  localparam int PRW  = ((W > DSHW) ? W : DSHW) + 1;
  localparam int XW   = (TSW > 32) ? TSW : 32;
  localparam int NUMW = W1 + F;
  localparam int DB   = rsi_pkg::DIST_BITS;
  localparam int MB   = rsi_pkg::MAT_BITS;
  localparam int MIN_T = ((1 << F) + 500) / 1000;
  localparam int LAT  = 11 + SQW + NUMW;

  // configuration
  logic signed [W-1:0] cx_q, cy_q, cz_q;
  logic [RW-1:0]       radius_q;
  logic [MB-1:0]       material_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q       <= '0;
      cy_q       <= '0;
      cz_q       <= '0;
      radius_q   <= RW'(1) << F;
      material_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsi_pkg::CFG_CENTER_X: cx_q <= cfg_data_i;
        rsi_pkg::CFG_CENTER_Y: cy_q <= cfg_data_i;
        rsi_pkg::CFG_CENTER_Z: cz_q <= cfg_data_i;
        rsi_pkg::CFG_RADIUS:   radius_q <= cfg_data_i[RW-1:0];
        rsi_pkg::CFG_MATERIAL: material_q <= cfg_data_i[MB-1:0];
        default: ;
      endcase
    end
  end

  logic signed [W-1:0]  cen [3];
  logic signed [W-1:0]  o_in [3];
  logic signed [DW-1:0] d_in [3];
  logic                 acc;
  logic [RW-1:0]        rdiv;

  assign cen[0]  = cx_q;
  assign cen[1]  = cy_q;
  assign cen[2]  = cz_q;
  assign o_in[0] = origin_x_i;
  assign o_in[1] = origin_y_i;
  assign o_in[2] = origin_z_i;
  assign d_in[0] = dir_x_i;
  assign d_in[1] = dir_y_i;
  assign d_in[2] = dir_z_i;
  assign busy_o  = 1'b0;
  assign acc     = start_i && !busy_o;
  assign rdiv    = (radius_q == '0) ? RW'(1) : radius_q;

  // stage registers, front end
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [W-1:0]   o1_q [3], o2_q [3], o3_q [3], o4_q [3], o5_q [3];
  logic signed [DW-1:0]  d1_q [3], d2_q [3], d3_q [3], d4_q [3], d5_q [3];
  logic signed [OCW-1:0] oc1_q [3];
  logic signed [PDW-1:0] prd2_q [3];
  logic [SQOW-1:0]       sq2_q [3];
  logic [RRW-1:0]        rr2_q;
  logic signed [B2W-1:0] b2_3_q, b2_4_q, b2_5_q;
  logic signed [CCW-1:0] cc3_q, cc4_q, cc5_q;
  logic [2*LO-1:0]       p00_4_q;
  logic [LO+HI-1:0]      p01_4_q;
  logic [2*HI-1:0]       p11_4_q;
  logic [BBW-1:0]        bb5_q;

  logic [B2W-1:0]        bmag;
  logic signed [DSW-1:0] disc;

  always_comb begin
    bmag = b2_3_q[B2W-1] ? B2W'(-b2_3_q) : B2W'(b2_3_q);
    disc = $signed(DSW'(bb5_q)) - (DSW'(cc5_q) <<< (2 * F));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= acc;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      o1_q[i]   <= o_in[i];
      d1_q[i]   <= d_in[i];
      oc1_q[i]  <= OCW'(o_in[i]) - OCW'(cen[i]);
      o2_q[i]   <= o1_q[i];
      d2_q[i]   <= d1_q[i];
      prd2_q[i] <= PDW'(d1_q[i]) * PDW'(oc1_q[i]);
      sq2_q[i]  <= SQOW'($signed(SQOW'(oc1_q[i])) * $signed(SQOW'(oc1_q[i])));
      o3_q[i]   <= o2_q[i];
      d3_q[i]   <= d2_q[i];
      o4_q[i]   <= o3_q[i];
      d4_q[i]   <= d3_q[i];
      o5_q[i]   <= o4_q[i];
      d5_q[i]   <= d4_q[i];
    end
    rr2_q   <= RRW'(radius_q) * RRW'(radius_q);
    b2_3_q  <= B2W'(prd2_q[0]) + B2W'(prd2_q[1]) + B2W'(prd2_q[2]);
    cc3_q   <= $signed(CCW'(sq2_q[0]) + CCW'(sq2_q[1]) + CCW'(sq2_q[2]) - CCW'(rr2_q));
    b2_4_q  <= b2_3_q;
    cc4_q   <= cc3_q;
    p00_4_q <= (2*LO)'(bmag[LO-1:0]) * (2*LO)'(bmag[LO-1:0]);
    p01_4_q <= (LO+HI)'(bmag[B2W-1:LO]) * (LO+HI)'(bmag[LO-1:0]);
    p11_4_q <= (2*HI)'(bmag[B2W-1:LO]) * (2*HI)'(bmag[B2W-1:LO]);
    b2_5_q  <= b2_4_q;
    cc5_q   <= cc4_q;
    bb5_q   <= (BBW'(p11_4_q) << (2 * LO)) + (BBW'(p01_4_q) << (LO + 1)) + BBW'(p00_4_q);
  end

  // square root, one root bit per stage
  logic                  sq_v_q [SQW+1];
  logic                  sq_miss_q [SQW+1];
  logic signed [B2W-1:0] sq_b2_q [SQW+1];
  logic signed [W-1:0]   sq_o_q [SQW+1][3];
  logic signed [DW-1:0]  sq_d_q [SQW+1][3];
  logic [SQW-1:0]        sq_rem_q [SQW+1];
  logic [SQW-1:0]        sq_root_q [SQW+1];
  logic [RDW-1:0]        sq_rad_q [SQW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else begin
      sq_v_q[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_miss_q[0] <= disc[DSW-1];
    sq_b2_q[0]   <= b2_5_q;
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_rad_q[0]  <= disc[DSW-1] ? '0 : RDW'(disc);
    for (int i = 0; i < 3; i++) begin
      sq_o_q[0][i] <= o5_q[i];
      sq_d_q[0][i] <= d5_q[i];
    end
  end

  for (genvar k = 0; k < SQW; k++) begin : g_sqrt
    logic [SQW+1:0] tmp, trial, diff;
    logic           ge;
    always_comb begin
      tmp   = {sq_rem_q[k], sq_rad_q[k][RDW-1 -: 2]};
      trial = {sq_root_q[k], 2'b01};
      ge    = tmp >= trial;
      diff  = ge ? (tmp - trial) : tmp;
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      sq_miss_q[k+1] <= sq_miss_q[k];
      sq_b2_q[k+1]   <= sq_b2_q[k];
      sq_rem_q[k+1]  <= diff[SQW-1:0];
      sq_root_q[k+1] <= {sq_root_q[k][SQW-2:0], ge};
      sq_rad_q[k+1]  <= sq_rad_q[k] << 2;
      for (int i = 0; i < 3; i++) begin
        sq_o_q[k+1][i] <= sq_o_q[k][i];
        sq_d_q[k+1][i] <= sq_d_q[k][i];
      end
    end
  end

  // root select, point
  logic signed [TW-1:0] tn, tf, tq, minq;
  logic                 near_ok, far_ok;

  always_comb begin
    minq    = TW'(MIN_T) << F;
    tn      = -TW'(sq_b2_q[SQW]) - $signed(TW'(sq_root_q[SQW]));
    tf      = -TW'(sq_b2_q[SQW]) + $signed(TW'(sq_root_q[SQW]));
    near_ok = tn >= minq;
    far_ok  = tf >= minq;
    tq      = near_ok ? tn : tf;
  end

  logic                  v7_q, v8_q, v9_q;
  logic                  hit7_q, hit8_q, hit9_q, front7_q, front8_q, front9_q;
  logic signed [TSW-1:0] t7_q, t8_q;
  logic signed [W-1:0]   o7_q [3], o8_q [3], p9_q [3];
  logic signed [DW-1:0]  d7_q [3];
  logic signed [DTW-1:0] dt8_q [3];
  logic [DB-1:0]         dist9_q;
  logic signed [PRW-1:0] psum [3];
  logic signed [W-1:0]   psat [3];
  logic signed [XW-1:0]  t_ext;
  logic [DB-1:0]         dist_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = PRW'(o8_q[i]) + PRW'($signed(dt8_q[i][DTW-1:F]));
      if ((psum[i][PRW-1:W-1] == '0) || (psum[i][PRW-1:W-1] == '1)) begin
        psat[i] = psum[i][W-1:0];
      end else begin
        psat[i] = psum[i][PRW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end
    end
    t_ext  = XW'(t8_q);
    dist_d = (t_ext[XW-1:DB] != '0) ? '1 : t_ext[DB-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v7_q <= sq_v_q[SQW];
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hit7_q   <= !sq_miss_q[SQW] && (near_ok || far_ok);
    front7_q <= !sq_miss_q[SQW] && near_ok;
    t7_q     <= tq[TW-1:F];
    hit8_q   <= hit7_q;
    front8_q <= front7_q;
    t8_q     <= t7_q;
    hit9_q   <= hit8_q;
    front9_q <= front8_q;
    dist9_q  <= dist_d;
    for (int i = 0; i < 3; i++) begin
      o7_q[i]  <= sq_o_q[SQW][i];
      d7_q[i]  <= sq_d_q[SQW][i];
      o8_q[i]  <= o7_q[i];
      dt8_q[i] <= DTW'(d7_q[i]) * DTW'(t7_q);
      p9_q[i]  <= psat[i];
    end
  end

  // normal divider, one quotient bit per stage per axis
  logic                dv_v_q [NUMW+1];
  logic                dv_hit_q [NUMW+1];
  logic                dv_front_q [NUMW+1];
  logic [DB-1:0]       dv_dist_q [NUMW+1];
  logic signed [W-1:0] dv_p_q [NUMW+1][3];
  logic                dv_neg_q [NUMW+1][3];
  logic [RW-1:0]       dv_rem_q [NUMW+1][3];
  logic [NUMW-1:0]     dv_nq_q [NUMW+1][3];
  logic signed [W1-1:0] ndiff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ndiff[i] = W1'(p9_q[i]) - W1'(cen[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_hit_q[0]   <= hit9_q;
    dv_front_q[0] <= front9_q;
    dv_dist_q[0]  <= dist9_q;
    for (int i = 0; i < 3; i++) begin
      dv_p_q[0][i]   <= p9_q[i];
      dv_neg_q[0][i] <= ndiff[i][W1-1];
      dv_rem_q[0][i] <= '0;
      dv_nq_q[0][i]  <= {(ndiff[i][W1-1] ? W1'(-ndiff[i]) : W1'(ndiff[i])), {F{1'b0}}};
    end
  end

  for (genvar k = 0; k < NUMW; k++) begin : g_div
    logic [RW:0] tmp [3];
    logic [RW:0] sub [3];
    logic        ge [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tmp[i] = {dv_rem_q[k][i], dv_nq_q[k][i][NUMW-1]};
        ge[i]  = tmp[i] >= {1'b0, rdiv};
        sub[i] = ge[i] ? (tmp[i] - {1'b0, rdiv}) : tmp[i];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      dv_hit_q[k+1]   <= dv_hit_q[k];
      dv_front_q[k+1] <= dv_front_q[k];
      dv_dist_q[k+1]  <= dv_dist_q[k];
      for (int i = 0; i < 3; i++) begin
        dv_p_q[k+1][i]   <= dv_p_q[k][i];
        dv_neg_q[k+1][i] <= dv_neg_q[k][i];
        dv_rem_q[k+1][i] <= sub[i][RW-1:0];
        dv_nq_q[k+1][i]  <= {dv_nq_q[k][i][NUMW-2:0], ge[i]};
      end
    end
  end

  // output stage
  logic [NUMW-1:0]     q [3];
  logic signed [W-1:0] nsat [3];
  logic                out_hit;

  always_comb begin
    out_hit = dv_hit_q[NUMW];
    for (int i = 0; i < 3; i++) begin
      q[i] = dv_nq_q[NUMW][i];
      if (dv_neg_q[NUMW][i]) begin
        if ((q[i][NUMW-1:W-1] == '0) ||
            (q[i] == {{(NUMW-W){1'b0}}, 1'b1, {(W-1){1'b0}}})) begin
          nsat[i] = W'(NUMW'(0) - q[i]);
        end else begin
          nsat[i] = {1'b1, {(W-1){1'b0}}};
        end
      end else begin
        nsat[i] = (q[i][NUMW-1:W-1] == '0) ? q[i][W-1:0] : {1'b0, {(W-1){1'b1}}};
      end
    end
  end

  logic                out_v_q, out_hit_q, out_front_q;
  logic [DB-1:0]       out_dist_q;
  logic signed [W-1:0] out_p_q [3];
  logic signed [W-1:0] out_n_q [3];
  logic [MB-1:0]       out_mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= dv_v_q[NUMW];
    end
  end

  always_ff @(posedge clk_i) begin
    out_hit_q   <= out_hit;
    out_front_q <= out_hit && dv_front_q[NUMW];
    out_dist_q  <= out_hit ? dv_dist_q[NUMW] : '0;
    out_mat_q   <= material_q;
    for (int i = 0; i < 3; i++) begin
      out_p_q[i] <= out_hit ? dv_p_q[NUMW][i] : '0;
      out_n_q[i] <= out_hit ? nsat[i] : '0;
    end
  end

  assign valid_o      = out_v_q;
  assign hit_flag_o   = out_hit_q;
  assign front_face_o = out_front_q;
  assign distance_o   = out_dist_q;
  assign point_x_o    = out_p_q[0];
  assign point_y_o    = out_p_q[1];
  assign point_z_o    = out_p_q[2];
  assign normal_x_o   = out_n_q[0];
  assign normal_y_o   = out_n_q[1];
  assign normal_z_o   = out_n_q[2];
  assign material_o   = out_mat_q;

  `RSI_ASSERT_IMPL(a_out_has_ray, clk_i, rst_ni, valid_o, $past(acc, LAT))
  `RSI_ASSERT_IMPL(a_front_is_hit, clk_i, rst_ni, valid_o && front_face_o, hit_flag_o)
  `RSI_ASSERT_IMPL(a_hit_dist, clk_i, rst_ni, valid_o && hit_flag_o, distance_o != '0)
  `RSI_ASSERT_NEXT(a_dist_enters_div, clk_i, rst_ni, v9_q && hit9_q, dv_dist_q[0] != '0)

endmodule
